>>> sv/lsfa_pkg.sv
// Shared types, constants and helper functions for the LoRa spreading-factor adapter.
// Used by every module of the block but the divider; depends on nothing.
package lsfa_pkg;

  // Default history depth and the fixed port widths.
  localparam int HistDepthDef = 16;
  localparam int KindW        = 3;
  localparam int InDataW      = 24;
  localparam int OutDataW     = 128;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  // Spreading factor range and the minimum history for a re-evaluation to change the SF.
  localparam logic [3:0] SfLo       = 4'd7;
  localparam logic [3:0] SfHi       = 4'd12;
  localparam int         MinEntries = 5;

  // Strategy thresholds.
  localparam logic signed [7:0] RssiConsRaise = -8'sd112;
  localparam logic signed [7:0] RssiConsLower = -8'sd90;
  localparam logic signed [7:0] RssiBalLower  = -8'sd80;
  localparam logic signed [7:0] RssiFloor     = -8'sd115;
  localparam logic signed [7:0] SnrConsRaise  = 8'sd10;
  localparam logic signed [7:0] SnrConsLower  = 8'sd15;
  localparam logic signed [7:0] SnrBalLower   = 8'sd10;
  localparam logic signed [7:0] SnrFloor      = -8'sd5;

  typedef enum logic [2:0] {
    KIND_TX    = 3'd0,
    KIND_RX    = 3'd1,
    KIND_ACK   = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_CLEAR = 3'd4,
    KIND_FORCE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CFG_STRATEGY = 3'd0,
    CFG_LOWEST   = 3'd1,
    CFG_HIGHEST  = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_TARGET   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STRAT_CONS  = 2'd0,
    STRAT_BAL   = 2'd1,
    STRAT_AGGR  = 2'd2,
    STRAT_ADAPT = 2'd3
  } strategy_e;

  typedef enum logic [1:0] {
    DIV_RSSI = 2'd0,
    DIV_SNR  = 2'd1,
    DIV_RATE = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV_A,
    ST_WAIT_A,
    ST_DIV_B,
    ST_WAIT_B,
    ST_TICK_CHK,
    ST_EV_P,
    ST_EV_K1,
    ST_EV_K2,
    ST_EV_APPLY,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     exec;
    logic     sweep_run;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_store;
    logic     ev_p;
    logic     ev_k1;
    logic     ev_k2;
    logic     ev_apply;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  hist_empty;
    logic  sweep_last;
    logic  div_done;
    logic  tick_due;
    logic  out_free;
  } sts_t;

  // Packet airtime in milliseconds per spreading factor; zero outside 7..12.
  function automatic logic [10:0] airtime_ms(logic [3:0] sf);
    logic [10:0] a;
    case (sf)
      4'd7:    a = 11'd41;
      4'd8:    a = 11'd72;
      4'd9:    a = 11'd144;
      4'd10:   a = 11'd297;
      4'd11:   a = 11'd582;
      4'd12:   a = 11'd1152;
      default: a = 11'd0;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] clamp_sf(logic [3:0] v, logic [3:0] lo, logic [3:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [3:0] bound_hi(logic [3:0] highest);
    return clamp_sf(highest, SfLo, SfHi);
  endfunction

  function automatic logic [3:0] bound_lo(logic [3:0] lowest, logic [3:0] highest);
    logic [3:0] c;
    logic [3:0] h;
    c = clamp_sf(lowest, SfLo, SfHi);
    h = bound_hi(highest);
    return (c > h) ? h : c;
  endfunction

  function automatic logic [3:0] step_up(logic [3:0] s);
    return (s < SfHi) ? s + 4'd1 : s;
  endfunction

  function automatic logic [3:0] step_down(logic [3:0] s);
    return (s > SfLo) ? s - 4'd1 : s;
  endfunction

  // Strategy decision; low and high are the duty-cycle comparisons.
  function automatic logic [3:0] next_sf(logic [1:0] mode, logic [3:0] sf, logic [6:0] rate,
                                         logic signed [7:0] rs, logic signed [7:0] sn,
                                         logic low, logic high,
                                         logic [3:0] lo, logic [3:0] hi);
    logic [3:0] rec;
    rec = sf;
    case (strategy_e'(mode))
      STRAT_CONS: begin
        if (rate < 7'd95 || rs < RssiConsRaise || sn < SnrConsRaise) begin
          rec = step_up(rec);
        end else if (rate >= 7'd99 && rs > RssiConsLower && sn > SnrConsLower) begin
          rec = step_down(rec);
        end
      end
      STRAT_AGGR: begin
        if (rate >= 7'd70 && rs > RssiFloor && sn > SnrFloor) begin
          rec = step_down(rec);
        end else if (rate < 7'd50) begin
          rec = step_up(rec);
        end
      end
      default: begin
        // Adaptive applies the duty-cycle rule first, then the balanced rule.
        if (strategy_e'(mode) == STRAT_ADAPT) begin
          if (low) begin
            if (rate < 7'd98) begin
              rec = step_up(rec);
            end
          end else if (high) begin
            if (rate > 7'd95) begin
              rec = step_down(rec);
            end
          end
        end
        if (rate < 7'd70) begin
          rec = step_up(rec);
        end else if (rate > 7'd95 && rs > RssiBalLower && sn > SnrBalLower) begin
          rec = step_down(rec);
        end else if (rs < RssiFloor || sn < SnrFloor) begin
          rec = step_up(rec);
        end
      end
    endcase
    return clamp_sf(rec, lo, hi);
  endfunction

endpackage

>>> sv/lsfa_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by lsfa_datapath.
module lsfa_divider #(
  parameter int NumW = 12,
  parameter int DenW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] numer_i,
  input  logic [DenW-1:0] denom_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic            done_q;
  logic [DenW:0]   trial;
  logic            fits;

  // One trial subtraction per cycle.
  assign trial = {rem_q, quo_q[NumW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NumW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> sv/lsfa_datapath.sv
// Datapath: configuration, history memory, statistics, sweep, evaluation and result word.
// Depends on lsfa_pkg and lsfa_divider.
module lsfa_datapath #(
  parameter int HistDepth = lsfa_pkg::HistDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsfa_pkg::cmd_t                 cmd_i,
  output lsfa_pkg::sts_t                 sts_o,
  input  logic [lsfa_pkg::InDataW-1:0]   in_data_i,
  input  logic [lsfa_pkg::KindW-1:0]     in_kind_i,
  input  logic                           cfg_valid_i,
  input  logic [lsfa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lsfa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [lsfa_pkg::OutDataW-1:0]  out_data_o
);

  localparam int IdxW = $clog2(HistDepth);
  localparam int CntW = $clog2(HistDepth + 1);
  localparam int SumW = 8 + CntW;

  // Configuration registers.
  logic [1:0]  strat_q;
  logic [3:0]  lowest_q;
  logic [3:0]  highest_q;
  logic [31:0] period_q;
  logic [6:0]  target_q;

  // Latched item.
  lsfa_pkg::kind_e   kind_q;
  logic [3:0]        sfv_q;
  logic signed [7:0] rssi_in_q;
  logic signed [7:0] snr_in_q;
  logic              ack_q;

  // Statistics state.
  logic [IdxW-1:0]   ws_q;
  logic [CntW-1:0]   fill_q;
  logic [3:0]        sf_q;
  logic signed [7:0] rssi_mean_q;
  logic signed [7:0] snr_mean_q;
  logic [6:0]        rate_q;
  logic [31:0]       sent_q;
  logic [31:0]       acked_q;
  logic [31:0]       lost_q;
  logic [31:0]       airtime_q;
  logic [31:0]       window_q;
  logic [31:0]       since_q;
  logic              upd_q;

  // History memory.
  logic              success_mem [HistDepth];
  logic signed [7:0] rssi_mem    [HistDepth];
  logic signed [7:0] snr_mem     [HistDepth];

  // Sweep and accumulation.
  logic [CntW-1:0]       idx_q;
  logic                  rd_vld_q;
  logic                  succ_rd_q;
  logic signed [7:0]     rssi_rd_q;
  logic signed [7:0]     snr_rd_q;
  logic signed [SumW-1:0] rssi_sum_q;
  logic signed [SumW-1:0] snr_sum_q;
  logic [CntW-1:0]       good_q;

  // Evaluation products.
  logic [38:0] p_q;
  logic [38:0] k1_q;
  logic [38:0] k2_q;
  logic [5:0]  half_q;
  logic [6:0]  m_q;

  // Result register.
  logic                          out_vld_q;
  logic [lsfa_pkg::OutDataW-1:0] out_q;

  // Combinational helpers.
  logic [3:0]      lo_b;
  logic [3:0]      hi_b;
  logic [3:0]      cfg_lowest;
  logic [3:0]      cfg_highest;
  logic [IdxW-1:0] ws_next;
  logic [IdxW-1:0] newest;
  logic [32:0]     air_sum;
  logic [6:0]      tclamp;
  logic [9:0]      nine_t;
  logic [17:0]     m_prod;
  logic [37:0]     k1_w;
  logic [38:0]     k2_w;
  logic [38:0]     p_w;
  logic            duty_low;
  logic            duty_high;
  logic [3:0]      eval_sf;
  logic            cfg_sf_we;
  logic [SumW-1:0] rssi_mag;
  logic [SumW-1:0] snr_mag;
  logic [SumW-1:0] good_x100;
  logic [SumW-1:0] div_numer;
  logic [SumW-1:0] div_quot;
  logic            div_done;
  logic [SumW-1:0] signed_q;
  logic            neg_sel;

  assign lo_b    = lsfa_pkg::bound_lo(lowest_q, highest_q);
  assign hi_b    = lsfa_pkg::bound_hi(highest_q);
  assign ws_next = (ws_q == IdxW'(HistDepth - 1)) ? '0 : ws_q + 1'b1;
  assign newest  = (ws_q == '0) ? IdxW'(HistDepth - 1) : ws_q - 1'b1;
  assign air_sum = {1'b0, airtime_q} + 33'(lsfa_pkg::airtime_ms(sfv_q));

  // Target duty clamp, half of it, and floor(9T/10)+1 by reciprocal (exact below 1024).
  assign tclamp = (target_q == '0) ? 7'd1 : ((target_q > 7'd100) ? 7'd100 : target_q);
  assign nine_t = 10'(tclamp) * 10'd9;
  assign m_prod = 18'(nine_t) * 18'd205;

  // Duty products: duty < T/2 iff 100A < (T/2)W, 10*duty > 9T iff 100A >= mW.
  assign p_w  = 39'(airtime_q) * 39'd100;
  assign k1_w = window_q * half_q;
  assign k2_w = window_q * m_q;
  assign duty_low  = (window_q == '0) ? (half_q != '0) : (p_q < k1_q);
  assign duty_high = (window_q != '0) && (p_q >= k2_q);
  assign eval_sf   = lsfa_pkg::next_sf(strat_q, sf_q, rate_q, rssi_mean_q, snr_mean_q,
                                       duty_low, duty_high, lo_b, hi_b);

  // New bounds seen by a configuration write of either SF limit.
  assign cfg_lowest  = (lsfa_pkg::cfg_idx_e'(cfg_index_i) == lsfa_pkg::CFG_LOWEST)
                       ? cfg_data_i[3:0] : lowest_q;
  assign cfg_highest = (lsfa_pkg::cfg_idx_e'(cfg_index_i) == lsfa_pkg::CFG_HIGHEST)
                       ? cfg_data_i[3:0] : highest_q;
  assign cfg_sf_we   = cfg_valid_i &&
                       (lsfa_pkg::cfg_idx_e'(cfg_index_i) == lsfa_pkg::CFG_LOWEST ||
                        lsfa_pkg::cfg_idx_e'(cfg_index_i) == lsfa_pkg::CFG_HIGHEST);

  // Divider operands.
  assign rssi_mag  = rssi_sum_q[SumW-1] ? SumW'(-rssi_sum_q) : rssi_sum_q;
  assign snr_mag   = snr_sum_q[SumW-1] ? SumW'(-snr_sum_q) : snr_sum_q;
  assign good_x100 = SumW'(good_q) * SumW'(100);

  always_comb begin
    unique case (cmd_i.div_sel)
      lsfa_pkg::DIV_RSSI: begin
        div_numer = rssi_mag;
        neg_sel   = rssi_sum_q[SumW-1];
      end
      lsfa_pkg::DIV_SNR: begin
        div_numer = snr_mag;
        neg_sel   = snr_sum_q[SumW-1];
      end
      default: begin
        div_numer = good_x100;
        neg_sel   = 1'b0;
      end
    endcase
  end

  assign signed_q = neg_sel ? SumW'(-div_quot) : div_quot;

  lsfa_divider #(
    .NumW (SumW),
    .DenW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (div_numer),
    .denom_i (fill_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Item payload capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sfv_q     <= in_data_i[3:0];
      rssi_in_q <= in_data_i[11:4];
      snr_in_q  <= in_data_i[19:12];
      ack_q     <= in_data_i[20];
    end
  end

  // History memory: one write port, one registered read port per array.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && kind_q == lsfa_pkg::KIND_TX) begin
      success_mem[ws_q] <= 1'b0;
      rssi_mem[ws_q]    <= '0;
      snr_mem[ws_q]     <= '0;
    end else if (cmd_i.exec && kind_q == lsfa_pkg::KIND_RX && fill_q != '0) begin
      rssi_mem[newest] <= rssi_in_q;
      snr_mem[newest]  <= snr_in_q;
    end else if (cmd_i.exec && kind_q == lsfa_pkg::KIND_ACK && fill_q != '0) begin
      success_mem[newest] <= ack_q;
    end
    if (cmd_i.sweep_run) begin
      succ_rd_q <= success_mem[idx_q[IdxW-1:0]];
      rssi_rd_q <= rssi_mem[idx_q[IdxW-1:0]];
      snr_rd_q  <= snr_mem[idx_q[IdxW-1:0]];
    end
  end

  // Sweep accumulators, cleared by the execute step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rssi_sum_q <= '0;
      snr_sum_q  <= '0;
      good_q     <= '0;
    end else if (rd_vld_q) begin
      rssi_sum_q <= rssi_sum_q + SumW'(rssi_rd_q);
      snr_sum_q  <= snr_sum_q + SumW'(snr_rd_q);
      good_q     <= good_q + CntW'(succ_rd_q);
    end
  end

  // Evaluation product stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_p) begin
      p_q    <= p_w;
      half_q <= tclamp[6:1];
      m_q    <= m_prod[17:11] + 7'd1;
    end
    if (cmd_i.ev_k1) begin
      k1_q <= 39'(k1_w);
    end
    if (cmd_i.ev_k2) begin
      k2_q <= k2_w;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {4'b0, lost_q, acked_q, sent_q, snr_mean_q, rssi_mean_q, rate_q, upd_q, sf_q};
    end
  end

  // Control and statistics state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q     <= lsfa_pkg::STRAT_BAL;
      lowest_q    <= 4'd7;
      highest_q   <= 4'd12;
      period_q    <= 32'd30000;
      target_q    <= 7'd80;
      kind_q      <= lsfa_pkg::KIND_TX;
      ws_q        <= '0;
      fill_q      <= '0;
      sf_q        <= lsfa_pkg::SfLo;
      rssi_mean_q <= '0;
      snr_mean_q  <= '0;
      rate_q      <= '0;
      sent_q      <= '0;
      acked_q     <= '0;
      lost_q      <= '0;
      airtime_q   <= '0;
      window_q    <= '0;
      since_q     <= '0;
      upd_q       <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.sweep_run;
      if (cmd_i.latch) begin
        kind_q <= lsfa_pkg::kind_e'(in_kind_i);
        upd_q  <= 1'b0;
      end
      if (cmd_i.sweep_run) begin
        idx_q <= idx_q + 1'b1;
      end
      // Execute-step update for each kind of item.
      if (cmd_i.exec) begin
        idx_q <= '0;
        unique case (kind_q)
          lsfa_pkg::KIND_TX: begin
            sent_q    <= sent_q + 32'd1;
            airtime_q <= air_sum[32] ? '1 : air_sum[31:0];
            ws_q      <= ws_next;
            if (fill_q != CntW'(HistDepth)) begin
              fill_q <= fill_q + 1'b1;
            end
          end
          lsfa_pkg::KIND_ACK: begin
            if (ack_q) begin
              acked_q <= acked_q + 32'd1;
            end else begin
              lost_q <= lost_q + 32'd1;
            end
          end
          lsfa_pkg::KIND_TICK: begin
            window_q <= window_q + 32'd1;
            since_q  <= since_q + 32'd1;
          end
          lsfa_pkg::KIND_CLEAR: begin
            ws_q        <= '0;
            fill_q      <= '0;
            rssi_mean_q <= '0;
            snr_mean_q  <= '0;
            rate_q      <= '0;
            sent_q      <= '0;
            acked_q     <= '0;
            lost_q      <= '0;
            airtime_q   <= '0;
            window_q    <= '0;
            sf_q        <= lsfa_pkg::SfHi;
          end
          lsfa_pkg::KIND_FORCE: begin
            sf_q <= lsfa_pkg::clamp_sf(sfv_q, lo_b, hi_b);
          end
          default: begin
          end
        endcase
      end
      // Re-evaluation finishes: new SF if enough history, window restarts.
      if (cmd_i.ev_apply) begin
        if (fill_q >= CntW'(lsfa_pkg::MinEntries)) begin
          sf_q <= eval_sf;
        end
        since_q   <= '0;
        window_q  <= '0;
        airtime_q <= '0;
        upd_q     <= 1'b1;
      end
      // Store a finished quotient.
      if (cmd_i.div_store) begin
        unique case (cmd_i.div_sel)
          lsfa_pkg::DIV_RSSI: rssi_mean_q <= signed_q[7:0];
          lsfa_pkg::DIV_SNR:  snr_mean_q  <= signed_q[7:0];
          default:            rate_q      <= div_quot[6:0];
        endcase
      end
      // Configuration writes; an SF limit write also clamps the current SF.
      if (cfg_valid_i) begin
        unique case (lsfa_pkg::cfg_idx_e'(cfg_index_i))
          lsfa_pkg::CFG_STRATEGY: strat_q   <= cfg_data_i[1:0];
          lsfa_pkg::CFG_LOWEST:   lowest_q  <= cfg_data_i[3:0];
          lsfa_pkg::CFG_HIGHEST:  highest_q <= cfg_data_i[3:0];
          lsfa_pkg::CFG_PERIOD:   period_q  <= cfg_data_i;
          lsfa_pkg::CFG_TARGET:   target_q  <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
      if (cfg_sf_we) begin
        sf_q <= lsfa_pkg::clamp_sf(sf_q, lsfa_pkg::bound_lo(cfg_lowest, cfg_highest),
                                   lsfa_pkg::bound_hi(cfg_highest));
      end
      // Result register handshake.
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  assign sts_o.kind       = kind_q;
  assign sts_o.hist_empty = (fill_q == '0);
  assign sts_o.sweep_last = (idx_q == fill_q - 1'b1);
  assign sts_o.div_done   = div_done;
  assign sts_o.tick_due   = (since_q >= period_q);
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/lsfa_ctrl.sv
// Controller state machine sequencing the datapath for one item at a time.
// Depends on lsfa_pkg.
module lsfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsfa_pkg::sts_t sts_i,
  output lsfa_pkg::cmd_t cmd_o
);

  lsfa_pkg::state_e state_q;
  lsfa_pkg::state_e state_d;
  logic             is_ack;

  assign is_ack = (sts_i.kind == lsfa_pkg::KIND_ACK);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = is_ack ? lsfa_pkg::DIV_RATE : lsfa_pkg::DIV_RSSI;
    in_ready_o    = 1'b0;
    unique case (state_q)
      lsfa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = lsfa_pkg::ST_EXEC;
        end
      end
      lsfa_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (sts_i.kind) inside
          lsfa_pkg::KIND_RX, lsfa_pkg::KIND_ACK: begin
            state_d = sts_i.hist_empty ? lsfa_pkg::ST_DONE : lsfa_pkg::ST_SWEEP;
          end
          lsfa_pkg::KIND_TICK: state_d = lsfa_pkg::ST_TICK_CHK;
          default:             state_d = lsfa_pkg::ST_DONE;
        endcase
      end
      lsfa_pkg::ST_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = lsfa_pkg::ST_DRAIN;
        end
      end
      lsfa_pkg::ST_DRAIN: state_d = lsfa_pkg::ST_DIV_A;
      lsfa_pkg::ST_DIV_A: begin
        cmd_o.div_start = 1'b1;
        state_d         = lsfa_pkg::ST_WAIT_A;
      end
      lsfa_pkg::ST_WAIT_A: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = is_ack ? lsfa_pkg::ST_DONE : lsfa_pkg::ST_DIV_B;
        end
      end
      lsfa_pkg::ST_DIV_B: begin
        cmd_o.div_sel   = lsfa_pkg::DIV_SNR;
        cmd_o.div_start = 1'b1;
        state_d         = lsfa_pkg::ST_WAIT_B;
      end
      lsfa_pkg::ST_WAIT_B: begin
        cmd_o.div_sel = lsfa_pkg::DIV_SNR;
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = lsfa_pkg::ST_DONE;
        end
      end
      lsfa_pkg::ST_TICK_CHK: begin
        state_d = sts_i.tick_due ? lsfa_pkg::ST_EV_P : lsfa_pkg::ST_DONE;
      end
      lsfa_pkg::ST_EV_P: begin
        cmd_o.ev_p = 1'b1;
        state_d    = lsfa_pkg::ST_EV_K1;
      end
      lsfa_pkg::ST_EV_K1: begin
        cmd_o.ev_k1 = 1'b1;
        state_d     = lsfa_pkg::ST_EV_K2;
      end
      lsfa_pkg::ST_EV_K2: begin
        cmd_o.ev_k2 = 1'b1;
        state_d     = lsfa_pkg::ST_EV_APPLY;
      end
      lsfa_pkg::ST_EV_APPLY: begin
        cmd_o.ev_apply = 1'b1;
        state_d        = lsfa_pkg::ST_DONE;
      end
      lsfa_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = lsfa_pkg::ST_IDLE;
        end
      end
      default: state_d = lsfa_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> sv/lora_spreading_factor_adapter.sv
// Top level of the adaptive LoRa spreading-factor adapter.
// Depends on lsfa_pkg, lsfa_ctrl and lsfa_datapath.
//
//   Channel  Direction  Word contents
//   s_axis   in         tuser kind; tdata sf_value, rssi_dbm, snr_db, ack_ok
//   m_axis   out        tdata rec_sf ... lost_count, one word per input word
//   cfg      in         register index and write data, always ready
//
// Steps per word: the word is latched, then executed. Transmit, clear, force SF and
// unused kinds then load the result; a tick checks its period and, if due, runs the
// P, K1, K2 and apply steps; a receive or an ack loads at once if the history is
// empty, else sweeps the history, then the bit-serial divider gives the success rate
// for an ack, or the mean RSSI and then the mean SNR for a receive.
// Reset needs no clearing pass: only entries below the fill level are ever read.
// One result word is held at the output; with it still unread, the next word's
// processing waits in its last step before loading a new result.
module lora_spreading_factor_adapter #(
  parameter int HistoryDepth = lsfa_pkg::HistDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lsfa_pkg::InDataW-1:0]  s_axis_tdata,   // sf_value, rssi_dbm, snr_db, ack_ok
  input  logic [lsfa_pkg::KindW-1:0]    s_axis_tuser,   // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rec_sf, sf_updated, success_percent, mean_rssi, mean_snr,
  // sent_count, acked_count, lost_count
  output logic [lsfa_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsfa_pkg::CfgDataW-1:0] cfg_data_i
);

  lsfa_pkg::cmd_t cmd;
  lsfa_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lsfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsfa_datapath #(
    .HistDepth (HistoryDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // One word in flight: no new word is taken right after one is accepted.
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  // The reported SF always stays within the LoRa range.
  a_sf_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] >= 4'd7 && m_axis_tdata[3:0] <= 4'd12))
    else $error("reported SF out of range");

  // The success rate is a percentage.
  a_rate_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:5] <= 7'd100))
    else $error("success percent above 100");

endmodule
